// ----- hw/rtl/hex_command_line_parser_defines.svh -----
// Assertion macros for the hex command line parser.
`ifndef HEX_COMMAND_LINE_PARSER_DEFINES_SVH
`define HEX_COMMAND_LINE_PARSER_DEFINES_SVH

// Same-cycle implication, checked at every clock edge outside reset.
`define HCP_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked at every clock edge outside reset.
`define HCP_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- hw/rtl/hcp_pkg.sv -----
// Shared types and constants of the hex command line parser.
`timescale 1ns / 1ps
`default_nettype none

package hcp_pkg;

   localparam int CHAR_W  = 8;
   localparam int COUNT_W = 10;
   localparam int STAT_W  = 3;

   localparam logic [CHAR_W-1:0]  CHAR_TERM  = 8'h00;
   localparam logic [CHAR_W-1:0]  CHAR_SPACE = 8'h20;
   localparam logic [COUNT_W-1:0] MAX_BYTES_RESET = 10'd255;

   localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
   localparam logic [STAT_W-1:0] ST_EXTRA    = 3'd1;
   localparam logic [STAT_W-1:0] ST_NO_SPACE = 3'd2;
   localparam logic [STAT_W-1:0] ST_NO_HEX   = 3'd3;
   localparam logic [STAT_W-1:0] ST_TRAILING = 3'd4;

   typedef enum logic [2:0] {
      PH_CMD,
      PH_SEP,
      PH_HI,
      PH_LO,
      PH_DONE,
      PH_DISCARD
   } phase_type;

   // One classified character as it travels from front to back.
   typedef struct packed {
      logic [CHAR_W-1:0] ch;
      logic              is_term;
      logic              is_space;
      logic              is_hex;
      logic [3:0]        nib;
   } item_type;

endpackage

`default_nettype wire

// ----- hw/rtl/hcp_front.sv -----
// Front end: takes request characters and classifies them for the parser.
`timescale 1ns / 1ps
`default_nettype none

module hcp_front
   import hcp_pkg::*;
(
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire logic [CHAR_W-1:0] req_ch,
   output logic                   push_valid,
   input  wire logic              push_ready,
   output item_type               push_item
);

   logic       is_digit;
   logic       is_lower;
   logic       is_upper;
   logic [3:0] nib;

   always_comb begin
      is_digit = (req_ch >= 8'h30) && (req_ch <= 8'h39);
      is_lower = (req_ch >= 8'h61) && (req_ch <= 8'h66);
      is_upper = (req_ch >= 8'h41) && (req_ch <= 8'h46);
      // letters a..f and A..F share the low nibble 1..6
      if (is_digit) begin
         nib = req_ch[3:0];
      end else begin
         nib = req_ch[3:0] + 4'd9;
      end
   end

   always_comb begin
      push_item.ch       = req_ch;
      push_item.is_term  = (req_ch == CHAR_TERM);
      push_item.is_space = (req_ch == CHAR_SPACE);
      push_item.is_hex   = is_digit || is_lower || is_upper;
      push_item.nib      = nib;
   end

   assign push_valid = req_valid;
   assign req_ready  = push_ready;

endmodule

`default_nettype wire

// ----- hw/rtl/hcp_queue.sv -----
// Short queue of classified characters between front and back.
`timescale 1ns / 1ps
`default_nettype none

module hcp_queue
   import hcp_pkg::*;
#(
   parameter int DEPTH = 4
) (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     push_valid,
   output logic          push_ready,
   input  wire item_type push_item,
   output logic          pop_valid,
   input  wire logic     pop_ready,
   output item_type      pop_item
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   item_type        mem_ff [DEPTH];
   logic [AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]   count_ff, count_in;
   logic            do_push;
   logic            do_pop;

   assign push_ready = (count_ff != CW'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_item   = mem_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + AW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + AW'(1);
      end
      case ({do_push, do_pop})
         2'b10:   count_in = count_ff + CW'(1);
         2'b01:   count_in = count_ff - CW'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

`default_nettype wire

// ----- hw/rtl/hcp_back.sv -----
// Back end: parser state machine, byte count limit and response register.
`timescale 1ns / 1ps
`default_nettype none

module hcp_back
   import hcp_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               csr_write_enable,
   input  wire logic [COUNT_W-1:0] csr_write_data,
   input  wire logic               pop_valid,
   output logic                    pop_ready,
   input  wire item_type           pop_item,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic                    rsp_is_line_end,
   output logic [CHAR_W-1:0]       rsp_data_byte,
   output logic [CHAR_W-1:0]       rsp_command_char,
   output logic [STAT_W-1:0]       rsp_status,
   output logic [COUNT_W-1:0]      rsp_byte_count
);

   logic [COUNT_W-1:0] max_bytes_ff;
   phase_type          phase_ff, phase_in;
   logic [CHAR_W-1:0]  cmd_ff, cmd_in;
   logic [3:0]         hi_ff, hi_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [STAT_W-1:0]  err_ff, err_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic               line_end_ff;
   logic [CHAR_W-1:0]  data_ff;
   logic [CHAR_W-1:0]  cmd_out_ff;
   logic [STAT_W-1:0]  status_ff;
   logic [COUNT_W-1:0] bcount_ff;

   logic               pop;
   phase_type          eff_phase;
   logic [COUNT_W-1:0] count_inc;
   logic [STAT_W-1:0]  bad_digit_err;

   logic               res_valid;
   logic               res_line_end;
   logic [CHAR_W-1:0]  res_data;
   logic [CHAR_W-1:0]  res_cmd;
   logic [STAT_W-1:0]  res_status;
   logic [COUNT_W-1:0] res_count;

   // advance only when the response register is free or being drained
   assign pop_ready = !rsp_valid_ff || rsp_ready;
   assign pop       = pop_valid && pop_ready;
   assign count_inc = count_ff + COUNT_W'(1);
   assign bad_digit_err = (count_ff == '0) ? ST_NO_HEX : ST_TRAILING;

   // a full count awaiting a high digit means the line is complete
   always_comb begin
      if ((phase_ff == PH_HI) && (count_ff >= max_bytes_ff)) begin
         eff_phase = PH_DONE;
      end else begin
         eff_phase = phase_ff;
      end
   end

   // next state
   always_comb begin
      phase_in = phase_ff;
      cmd_in   = cmd_ff;
      hi_in    = hi_ff;
      count_in = count_ff;
      err_in   = err_ff;
      if (pop) begin
         if (pop_item.is_term) begin
            phase_in = PH_CMD;
            hi_in    = '0;
            count_in = '0;
            err_in   = ST_OK;
            if (eff_phase == PH_CMD) begin
               cmd_in = '0;
            end
         end else begin
            case (eff_phase)
               PH_CMD: begin
                  cmd_in   = pop_item.ch;
                  phase_in = PH_SEP;
               end
               PH_SEP: begin
                  if (max_bytes_ff == '0) begin
                     err_in   = ST_EXTRA;
                     phase_in = PH_DISCARD;
                  end else if (pop_item.is_space) begin
                     phase_in = PH_HI;
                  end else begin
                     err_in   = ST_NO_SPACE;
                     phase_in = PH_DISCARD;
                  end
               end
               PH_HI: begin
                  if (pop_item.is_hex) begin
                     hi_in    = pop_item.nib;
                     phase_in = PH_LO;
                  end else begin
                     err_in   = bad_digit_err;
                     phase_in = PH_DISCARD;
                  end
               end
               PH_LO: begin
                  if (pop_item.is_hex) begin
                     count_in = count_inc;
                     phase_in = (count_inc >= max_bytes_ff) ? PH_DONE : PH_HI;
                  end else begin
                     err_in   = bad_digit_err;
                     phase_in = PH_DISCARD;
                  end
               end
               PH_DONE: begin
                  err_in   = ST_TRAILING;
                  phase_in = PH_DISCARD;
               end
               default: begin
                  phase_in = phase_ff;
               end
            endcase
         end
      end
   end

   // response for the popped character
   always_comb begin
      res_valid    = 1'b0;
      res_line_end = 1'b0;
      res_data     = '0;
      res_cmd      = cmd_ff;
      res_status   = ST_OK;
      res_count    = count_ff;
      if (pop_item.is_term) begin
         res_valid    = 1'b1;
         res_line_end = 1'b1;
         case (eff_phase)
            PH_CMD: begin
               res_cmd    = '0;
               res_status = (max_bytes_ff == '0) ? ST_OK : ST_NO_SPACE;
            end
            PH_SEP:  res_status = (max_bytes_ff == '0) ? ST_OK : ST_NO_SPACE;
            PH_HI:   res_status = (count_ff == '0) ? ST_NO_HEX : ST_OK;
            PH_LO:   res_status = bad_digit_err;
            PH_DONE: res_status = ST_OK;
            default: res_status = err_ff;
         endcase
      end else if ((eff_phase == PH_LO) && pop_item.is_hex) begin
         res_valid = 1'b1;
         res_data  = {hi_ff, pop_item.nib};
         res_count = count_inc;
      end
   end

   always_comb begin
      if (pop_ready) begin
         rsp_valid_in = pop && res_valid;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_bytes_ff <= MAX_BYTES_RESET;
         phase_ff     <= PH_CMD;
         cmd_ff       <= '0;
         hi_ff        <= '0;
         count_ff     <= '0;
         err_ff       <= ST_OK;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            max_bytes_ff <= csr_write_data;
         end
         phase_ff     <= phase_in;
         cmd_ff       <= cmd_in;
         hi_ff        <= hi_in;
         count_ff     <= count_in;
         err_ff       <= err_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop && res_valid) begin
         line_end_ff <= res_line_end;
         data_ff     <= res_data;
         cmd_out_ff  <= res_cmd;
         status_ff   <= res_status;
         bcount_ff   <= res_count;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_is_line_end  = line_end_ff;
   assign rsp_data_byte    = data_ff;
   assign rsp_command_char = cmd_out_ff;
   assign rsp_status       = status_ff;
   assign rsp_byte_count   = bcount_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/hex_command_line_parser.sv -----
// Top level of the hex command line parser.
// Parses a command line fed one character per request, ended by a zero character: a
// command letter, a space, then hex digit pairs up to csr max_bytes (reset 255). Each
// decoded byte comes out as a data response; the terminator gives one end-of-line
// response with the first error (0 ok, 1 extra text, 2 no space, 3 no hex, 4 trailing).
// A request is taken every cycle while the queue has room: the parser state register
// updates once per character, so throughput is one character per clock while responses
// do not stall. A response is presented after its request enters the QUEUE_DEPTH-entry
// queue at the accepting edge and the back end pops it and loads the response register.
// The queue lets the request side keep going while responses stall, until it fills.
// Write max_bytes only while no request is in flight; it applies from the next character.
`timescale 1ns / 1ps
`default_nettype none

`include "hex_command_line_parser_defines.svh"

module hex_command_line_parser
   import hcp_pkg::*;
#(
   parameter int QUEUE_DEPTH = 4
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               csr_write_enable,
   input  wire logic [COUNT_W-1:0] csr_write_data,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic [CHAR_W-1:0]  req_ch,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic                    rsp_is_line_end,
   output logic [CHAR_W-1:0]       rsp_data_byte,
   output logic [CHAR_W-1:0]       rsp_command_char,
   output logic [STAT_W-1:0]       rsp_status,
   output logic [COUNT_W-1:0]      rsp_byte_count
);

   logic     push_valid;
   logic     push_ready;
   item_type push_item;
   logic     pop_valid;
   logic     pop_ready;
   item_type pop_item;

   hcp_front u_front (
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_ch     (req_ch),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item)
   );

   hcp_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_item   (pop_item)
   );

   hcp_back u_back (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .pop_valid        (pop_valid),
      .pop_ready        (pop_ready),
      .pop_item         (pop_item),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_is_line_end  (rsp_is_line_end),
      .rsp_data_byte    (rsp_data_byte),
      .rsp_command_char (rsp_command_char),
      .rsp_status       (rsp_status),
      .rsp_byte_count   (rsp_byte_count)
   );

   `HCP_ASSERT_IMP(a_data_rsp_shape, clock, reset, rsp_valid && !rsp_is_line_end, (rsp_status == ST_OK) && (rsp_byte_count != '0), "data response with error status or zero count")
   `HCP_ASSERT_IMP(a_end_rsp_shape, clock, reset, rsp_valid && rsp_is_line_end, (rsp_data_byte == '0) && (rsp_status <= ST_TRAILING), "end-of-line response with data or bad status")
   `HCP_ASSERT_IMP(a_ready_fall, clock, reset, $fell(req_ready), $past(req_valid && req_ready), "queue filled without a request")
   `HCP_ASSERT_NEXT(a_rsp_held, clock, reset, rsp_valid && !rsp_ready, rsp_valid, "stalled response dropped")

endmodule

`default_nettype wire
